@@ hw/rtl/cbez_pkg.sv @@
// ----------------------------------------------------------------------------
// cbez_pkg
// Shared constants and types for the cubic Bezier point and tangent core.
// ----------------------------------------------------------------------------
package cbez_pkg;

	localparam int COORD_WIDTH_DEF = 16;
	localparam int T_FRAC_BITS_DEF = 16;

	localparam int CFG_INDEX_W = 2;
	typedef logic [CFG_INDEX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t CFG_CP0 = 2'd0;
	localparam cfg_idx_t CFG_CP1 = 2'd1;
	localparam cfg_idx_t CFG_CP2 = 2'd2;
	localparam cfg_idx_t CFG_CP3 = 2'd3;

endpackage

@@ hw/rtl/cubic_bezier_point_and_tangent_core.sv @@
// ----------------------------------------------------------------------------
// cubic_bezier_point_and_tangent_core
// Evaluates a 3-D cubic Bezier curve and its first derivative at parameter t.
// Each input passes through stage registers s1 to s7 in order, and its result
// is presented from the stage 7 register. Throughput is one item per cycle; the
// seven-stage pipeline stalls as a whole when the output register holds a
// result that is not taken.
// Reset clears all stage valid bits and sets the four control points to zero.
// ----------------------------------------------------------------------------
module cubic_bezier_point_and_tangent_core #(
	parameter int COORD_WIDTH = cbez_pkg::COORD_WIDTH_DEF,
	parameter int T_FRAC_BITS = cbez_pkg::T_FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,

	input  logic                          cfg_wr_en,
	input  cbez_pkg::cfg_idx_t            cfg_index,
	input  logic [3*COORD_WIDTH-1:0]      cfg_data,

	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [T_FRAC_BITS:0]          t_param,

	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [COORD_WIDTH-1:0] point_x,
	output logic signed [COORD_WIDTH-1:0] point_y,
	output logic signed [COORD_WIDTH-1:0] point_z,
	output logic signed [COORD_WIDTH+2:0] slope_x,
	output logic signed [COORD_WIDTH+2:0] slope_y,
	output logic signed [COORD_WIDTH+2:0] slope_z
);

	import cbez_pkg::*;

	localparam int CW     = COORD_WIDTH;
	localparam int TF     = T_FRAC_BITS;
	localparam int TW     = TF + 1;
	localparam int SQ_W   = 2 * TF + 1;
	localparam int CUBE_W = 3 * TF + 1;
	localparam int D_W    = 2 * TF + 2;
	localparam int PP_W   = CW + CUBE_W + 1;
	localparam int PS_W   = CW + CUBE_W + 3;
	localparam int SD_W   = CW + 1;
	localparam int SP_W   = SD_W + D_W + 1;
	localparam int SS_W   = SP_W + 2;
	localparam int OW     = CW + 3;

	localparam logic [TW-1:0]   T_ONE  = {1'b1, {TF{1'b0}}};
	localparam logic [PS_W-1:0] P_HALF = PS_W'(1) << (3 * TF - 1);
	localparam logic [SS_W-1:0] S_HALF = SS_W'(1) << (2 * TF - 1);

	logic [3*CW-1:0] cp_q [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 4; k++) begin
				cp_q[k] <= '0;
			end
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_CP0: cp_q[0] <= cfg_data;
				CFG_CP1: cp_q[1] <= cfg_data;
				CFG_CP2: cp_q[2] <= cfg_data;
				CFG_CP3: cp_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic adv;

	assign adv       = !vld_s7 || out_ready;
	assign in_ready  = adv;
	assign out_valid = vld_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	// Stage 1: clamp t to one and form s = 1 - t.
	logic [TW-1:0] t_s1, s_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s1 <= (t_param > T_ONE) ? T_ONE : t_param;
			s_s1 <= T_ONE - ((t_param > T_ONE) ? T_ONE : t_param);
		end
	end

	// Stage 2: second-order products.
	logic [TW-1:0]   t_s2, s_s2;
	logic [SQ_W-1:0] ss_s2, st_s2, tt_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s2  <= t_s1;
			s_s2  <= s_s1;
			ss_s2 <= SQ_W'(s_s1) * SQ_W'(s_s1);
			st_s2 <= SQ_W'(s_s1) * SQ_W'(t_s1);
			tt_s2 <= SQ_W'(t_s1) * SQ_W'(t_s1);
		end
	end

	// Stage 3: Bernstein weights for the point and the derivative.
	logic [CUBE_W+1:0] w0_full, w1_full, w2_full, w3_full;
	logic [CUBE_W-1:0] w_s3 [4];
	logic [D_W-1:0]    d_s3 [3];

	assign w0_full = (CUBE_W+2)'(ss_s2) * (CUBE_W+2)'(s_s2);
	assign w1_full = (CUBE_W+2)'(ss_s2) * (CUBE_W+2)'(t_s2) * (CUBE_W+2)'(3);
	assign w2_full = (CUBE_W+2)'(st_s2) * (CUBE_W+2)'(t_s2) * (CUBE_W+2)'(3);
	assign w3_full = (CUBE_W+2)'(tt_s2) * (CUBE_W+2)'(t_s2);

	always_ff @(posedge clk) begin
		if (adv) begin
			w_s3[0] <= w0_full[CUBE_W-1:0];
			w_s3[1] <= w1_full[CUBE_W-1:0];
			w_s3[2] <= w2_full[CUBE_W-1:0];
			w_s3[3] <= w3_full[CUBE_W-1:0];
			d_s3[0] <= D_W'(ss_s2) + (D_W'(ss_s2) << 1);
			d_s3[1] <= (D_W'(st_s2) << 1) + (D_W'(st_s2) << 2);
			d_s3[2] <= D_W'(tt_s2) + (D_W'(tt_s2) << 1);
		end
	end

	logic signed [CW-1:0] pt_s7 [3];
	logic signed [OW-1:0] sl_s7 [3];

	for (genvar c = 0; c < 3; c++) begin : g_axis
		logic signed [CW-1:0]   b    [4];
		logic signed [SD_W-1:0] diff [3];
		logic signed [PP_W-1:0] pp_s4 [4];
		logic signed [SP_W-1:0] sp_s4 [3];
		logic signed [PS_W-1:0] pa_s5, pb_s5, ptot_s6, pround;
		logic signed [SS_W-1:0] sa_s5, sb_s5, stot_s6, sround;

		for (genvar k = 0; k < 4; k++) begin : g_cp
			assign b[k] = $signed(cp_q[k][c*CW +: CW]);
		end

		for (genvar k = 0; k < 3; k++) begin : g_diff
			assign diff[k] = $signed(SD_W'(b[k+1])) - $signed(SD_W'(b[k]));
		end

		// Stage 4: weighted control points and weighted differences.
		always_ff @(posedge clk) begin
			if (adv) begin
				for (int k = 0; k < 4; k++) begin
					pp_s4[k] <= $signed(PP_W'(b[k])) * $signed(PP_W'(w_s3[k]));
				end
				for (int k = 0; k < 3; k++) begin
					sp_s4[k] <= $signed(SP_W'(diff[k])) * $signed(SP_W'(d_s3[k]));
				end
			end
		end

		// Stage 5: pairwise sums.
		always_ff @(posedge clk) begin
			if (adv) begin
				pa_s5 <= $signed(PS_W'(pp_s4[0])) + $signed(PS_W'(pp_s4[1]));
				pb_s5 <= $signed(PS_W'(pp_s4[2])) + $signed(PS_W'(pp_s4[3]));
				sa_s5 <= $signed(SS_W'(sp_s4[0])) + $signed(SS_W'(sp_s4[1]));
				sb_s5 <= $signed(SS_W'(sp_s4[2]));
			end
		end

		// Stage 6: totals.
		always_ff @(posedge clk) begin
			if (adv) begin
				ptot_s6 <= pa_s5 + pb_s5;
				stot_s6 <= sa_s5 + sb_s5;
			end
		end

		// Stage 7: round to nearest with ties away from zero, then scale down.
		assign pround = ptot_s6 + $signed(P_HALF) - $signed(PS_W'(ptot_s6[PS_W-1]));
		assign sround = stot_s6 + $signed(S_HALF) - $signed(SS_W'(stot_s6[SS_W-1]));

		always_ff @(posedge clk) begin
			if (adv) begin
				pt_s7[c] <= $signed(pround[3*TF +: CW]);
				sl_s7[c] <= $signed(sround[2*TF +: OW]);
			end
		end
	end

	assign point_x = pt_s7[0];
	assign point_y = pt_s7[1];
	assign point_z = pt_s7[2];
	assign slope_x = sl_s7[0];
	assign slope_y = sl_s7[1];
	assign slope_z = sl_s7[2];

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the cubic Bezier point and tangent core. Loads a series of
// control point sets, from the reset state through the coordinate extremes,
// rounding ties and random sets, and streams curve parameters through the
// core under bursty input traffic and an irregular output stall pattern.
// A scoreboard computes each curve point and derivative exactly with wide
// integers and compares every result transfer field by field, in order.
// ----------------------------------------------------------------------------
module tb;
	import cbez_pkg::*;

	localparam int CW = COORD_WIDTH_DEF;
	localparam int TF = T_FRAC_BITS_DEF;
	localparam int ONE = 1 << TF;
	localparam int MAX_T = (1 << (TF + 1)) - 1;
	localparam logic [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};
	localparam logic [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam int HOLD_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int RANDOM_SETS = 7;
	localparam int ITEMS_PER_SET = 250;

	typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_PERIODIC} ready_mode_t;
	typedef enum int {SPREAD_FULL, SPREAD_SMALL, SPREAD_EXTREME} spread_t;

	typedef struct packed {
		logic signed [CW-1:0] px;
		logic signed [CW-1:0] py;
		logic signed [CW-1:0] pz;
		logic signed [CW+2:0] sx;
		logic signed [CW+2:0] sy;
		logic signed [CW+2:0] sz;
	} curve_sample_t;

	class bezier_scoreboard;
		logic [3*CW-1:0] points [4];
		curve_sample_t due [$];
		int n_checked;
		int n_failures;
		int n_clamped;

		function new();
			foreach (points[i]) points[i] = '0;
			n_checked = 0;
			n_failures = 0;
			n_clamped = 0;
		endfunction

		function void note_point(cfg_idx_t idx, logic [3*CW-1:0] value);
			points[idx] = value;
		endfunction

		// Divides by 2^k, rounding to nearest with halves away from zero.
		function logic signed [127:0] round_units(logic signed [127:0] acc, int k);
			logic [127:0] mag;
			mag = acc[127] ? -acc : acc;
			mag = (mag + (128'd1 << (k - 1))) >> k;
			return acc[127] ? -$signed(mag) : $signed(mag);
		endfunction

		function curve_sample_t eval_curve(logic [TF:0] t_raw);
			logic signed [127:0] t, s, b0, b1, b2, b3, acc;
			logic signed [127:0] pt [3];
			logic signed [127:0] sl [3];
			curve_sample_t r;
			t = '0;
			if (t_raw > ONE)
				t[TF:0] = (TF+1)'(ONE);
			else
				t[TF:0] = t_raw;
			s = 128'sd1 <<< TF;
			s = s - t;
			for (int c = 0; c < 3; c++) begin
				b0 = $signed(points[0][c*CW +: CW]);
				b1 = $signed(points[1][c*CW +: CW]);
				b2 = $signed(points[2][c*CW +: CW]);
				b3 = $signed(points[3][c*CW +: CW]);
				acc = b0*s*s*s + 3*b1*s*s*t + 3*b2*s*t*t + b3*t*t*t;
				pt[c] = round_units(acc, 3 * TF);
				acc = 3*s*s*(b1 - b0) + 6*s*t*(b2 - b1) + 3*t*t*(b3 - b2);
				sl[c] = round_units(acc, 2 * TF);
			end
			r.px = pt[0][CW-1:0];
			r.py = pt[1][CW-1:0];
			r.pz = pt[2][CW-1:0];
			r.sx = sl[0][CW+2:0];
			r.sy = sl[1][CW+2:0];
			r.sz = sl[2][CW+2:0];
			return r;
		endfunction

		function void note_t(logic [TF:0] t_raw);
			if (t_raw > ONE)
				n_clamped++;
			due = {due, eval_curve(t_raw)};
		endfunction

		function void report(string field, longint want, longint got);
			if (want != got) begin
				n_failures++;
				$display("time %0t: %s expected %0d, actual %0d", $time, field, want, got);
			end
		endfunction

		function void check_sample(curve_sample_t got);
			curve_sample_t want;
			if (due.size() == 0) begin
				n_failures++;
				$display("time %0t: result transfer with nothing pending, point %0d %0d %0d",
					$time, $signed(got.px), $signed(got.py), $signed(got.pz));
				return;
			end
			want = due.pop_front();
			n_checked++;
			report("point_x", $signed(want.px), $signed(got.px));
			report("point_y", $signed(want.py), $signed(got.py));
			report("point_z", $signed(want.pz), $signed(got.pz));
			report("slope_x", $signed(want.sx), $signed(got.sx));
			report("slope_y", $signed(want.sy), $signed(got.sy));
			report("slope_z", $signed(want.sz), $signed(got.sz));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	cfg_idx_t cfg_index;
	logic [3*CW-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic [TF:0] t_param;
	logic out_valid;
	logic out_ready;
	logic signed [CW-1:0] point_x, point_y, point_z;
	logic signed [CW+2:0] slope_x, slope_y, slope_z;

	bezier_scoreboard sb = new();
	logic [TF:0] t_plan [$];
	bit hold_req = 1'b0;
	int n_holds = 0;
	int n_sets = 0;

	cubic_bezier_point_and_tangent_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.t_param(t_param),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.point_x(point_x),
		.point_y(point_y),
		.point_z(point_z),
		.slope_x(slope_x),
		.slope_y(slope_y),
		.slope_z(slope_z)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [3*CW-1:0] pack_point(logic [CW-1:0] x, logic [CW-1:0] y,
			logic [CW-1:0] z);
		return {z, y, x};
	endfunction

	function automatic logic [3*CW-1:0] random_point(spread_t spread);
		logic [3*CW-1:0] v;
		logic [CW-1:0] c_val;
		v = '0;
		for (int c = 0; c < 3; c++) begin
			case (spread)
				SPREAD_SMALL: c_val = CW'($urandom_range(0, 127) - 64);
				SPREAD_EXTREME: begin
					case ($urandom_range(0, 4))
						0: c_val = C_MIN;
						1: c_val = C_MAX;
						2: c_val = '0;
						3: c_val = '1;
						default: c_val = CW'($urandom());
					endcase
				end
				default: c_val = CW'($urandom());
			endcase
			v[c*CW +: CW] = c_val;
		end
		return v;
	endfunction

	function automatic logic [TF:0] random_t();
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 4))
					0: return '0;
					1: return (TF+1)'(ONE);
					2: return (TF+1)'(ONE + 1);
					3: return (TF+1)'(ONE / 2);
					default: return (TF+1)'(MAX_T);
				endcase
			end
			1: return (TF+1)'($urandom_range(ONE + 1, MAX_T));
			2: return (TF+1)'($urandom_range(0, 255));
			3: return (TF+1)'(ONE - $urandom_range(0, 255));
			default: return (TF+1)'($urandom_range(0, ONE));
		endcase
	endfunction

	task automatic load_points(input logic [3*CW-1:0] p0, input logic [3*CW-1:0] p1,
			input logic [3*CW-1:0] p2, input logic [3*CW-1:0] p3);
		logic [3*CW-1:0] vals [4];
		cfg_idx_t idxs [4];
		vals = '{p0, p1, p2, p3};
		idxs = '{CFG_CP0, CFG_CP1, CFG_CP2, CFG_CP3};
		for (int i = 0; i < 4; i++) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= idxs[i];
			cfg_data <= vals[i];
			@(posedge clk);
			sb.note_point(idxs[i], vals[i]);
		end
		cfg_wr_en <= 1'b0;
		n_sets++;
	endtask

	task automatic stream_t_plan();
		int burst;
		int gap;
		burst = $urandom_range(1, 20);
		while (t_plan.size() > 0) begin
			in_valid <= 1'b1;
			t_param <= t_plan.pop_front();
			@(posedge clk);
			while (!in_ready) @(posedge clk);
			burst--;
			if (t_plan.size() == 0 || burst == 0) begin
				in_valid <= 1'b0;
				if (t_plan.size() > 0) begin
					gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30)
						: $urandom_range(1, 6);
					repeat (gap) @(posedge clk);
					burst = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
						: $urandom_range(1, 20);
				end
			end
		end
	endtask

	task automatic run_t_plan();
		stream_t_plan();
		while (sb.due.size() != 0) @(posedge clk);
	endtask

	initial begin
		ready_mode_t mode;
		int span;
		int tick;
		mode = READY_ALWAYS;
		span = 0;
		tick = 0;
		out_ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
				n_holds++;
			end else begin
				if (span == 0) begin
					mode = ready_mode_t'($urandom_range(0, 3));
					span = $urandom_range(10, 120);
				end
				span--;
				tick++;
				case (mode)
					READY_ALWAYS: out_ready <= 1'b1;
					READY_COIN: out_ready <= 1'($urandom_range(0, 1));
					READY_SPARSE: out_ready <= ($urandom_range(0, 7) == 0);
					default: out_ready <= (tick % 3 != 0);
				endcase
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		curve_sample_t got;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got.px = point_x;
				got.py = point_y;
				got.pz = point_z;
				got.sx = slope_x;
				got.sy = slope_y;
				got.sz = slope_z;
				sb.check_sample(got);
			end
			if (in_valid && in_ready)
				sb.note_t(t_param);
		end
	end

	initial begin
		int idle;
		idle = 0;
		while (idle < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
				idle = 0;
			else
				idle++;
		end
		$display("Stopped after %0d cycles without a transfer.", WATCHDOG_LIMIT);
		$display("cubic_bezier_point_and_tangent_core verification failed");
		$finish;
	end

	initial begin
		spread_t spreads [3];
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= CFG_CP0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		t_param <= '0;
		spreads = '{SPREAD_FULL, SPREAD_SMALL, SPREAD_EXTREME};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// All control points are still at their reset value of zero.
		t_plan = '{17'd0, 17'(ONE), 17'(MAX_T)};
		run_t_plan();

		load_points(pack_point(C_MIN, C_MIN, C_MIN), pack_point(C_MAX, C_MAX, C_MAX),
			pack_point(C_MIN, C_MIN, C_MIN), pack_point(C_MAX, C_MAX, C_MAX));
		t_plan = '{17'd0, 17'd1, 17'(ONE / 4), 17'(ONE / 2), 17'(ONE - 1), 17'(ONE),
			17'(ONE + 1), 17'(MAX_T)};
		run_t_plan();

		load_points(pack_point(C_MAX, C_MAX, C_MAX), pack_point(C_MIN, C_MIN, C_MIN),
			pack_point(C_MAX, C_MAX, C_MAX), pack_point(C_MIN, C_MIN, C_MIN));
		t_plan = '{17'd0, 17'(ONE / 3), 17'(ONE), 17'(ONE + ONE / 2)};
		run_t_plan();

		// At t of one half these points land exactly on halves in point_x, point_y and slope_z.
		load_points(pack_point(16'sd4, -16'sd4, 16'sd12), pack_point(16'sd0, 16'sd0, 16'sd2),
			'0, '0);
		t_plan = '{17'(ONE / 2), 17'(ONE / 2 + 1), 17'(ONE / 4)};
		run_t_plan();

		for (int set = 0; set < RANDOM_SETS; set++) begin
			load_points(random_point(spreads[$urandom_range(0, 2)]),
				random_point(spreads[$urandom_range(0, 2)]),
				random_point(spreads[$urandom_range(0, 2)]),
				random_point(spreads[set % 3]));
			repeat (ITEMS_PER_SET) t_plan = {t_plan, random_t()};
			if (set == 1)
				hold_req = 1'b1;
			run_t_plan();
		end

		repeat (15) @(posedge clk);
		$display("Checked %0d results over %0d control point sets, %0d with t above one.",
			sb.n_checked, n_sets + 1, sb.n_clamped);
		$display("Output held off for %0d cycles in %0d stretch(es) with input pending.",
			HOLD_CYCLES, n_holds);
		if (sb.n_failures == 0 && sb.due.size() == 0)
			$display("cubic_bezier_point_and_tangent_core verification clean");
		else
			$display("cubic_bezier_point_and_tangent_core verification failed");
		$finish;
	end
endmodule
